// ===== rtl/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper with clock.
// Used by cbm_rtc_tick and cartridge_bank_mapper_with_rtc_core; no dependencies.
`default_nettype none

package cbm_pkg;

    // Request codes on the input channel
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2,
        TGT_RTC  = 2'd3
    } t_target;

    // Configuration register indexes (byte address 4*index)
    localparam logic [1:0] REG_ROM_SIZE    = 2'd0;
    localparam logic [1:0] REG_RAM_PRESENT = 2'd1;
    localparam logic [1:0] REG_RAM_SIZE    = 2'd2;
    localparam logic [1:0] REG_RTC_PRESENT = 2'd3;

    localparam logic [4:0] ROM_SIZE_RESET = 5'd21;
    localparam logic [4:0] ROM_SIZE_MAX   = 5'd21;
    localparam logic [3:0] RAM_SIZE_RESET = 4'd15;

    // Bus address regions, decoded on address bits 15:13
    localparam logic [2:0] RGN_RAM_ENABLE = 3'b000;
    localparam logic [2:0] RGN_ROM_BANK   = 3'b001;
    localparam logic [2:0] RGN_RAM_SELECT = 3'b010;
    localparam logic [2:0] RGN_LATCH      = 3'b011;
    localparam logic [2:0] RGN_EXT_RAM    = 3'b101;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [7:0] LATCH_ARM      = 8'h00;
    localparam logic [7:0] LATCH_FIRE     = 8'h01;
    localparam logic [7:0] OPEN_BUS       = 8'hFF;

    // RAM bank select values: the last RAM bank, then the clock registers
    localparam logic [7:0] SEL_RAM_LAST = 8'h03;
    localparam logic [7:0] SEL_SECONDS  = 8'h08;
    localparam logic [7:0] SEL_MINUTES  = 8'h09;
    localparam logic [7:0] SEL_HOURS    = 8'h0A;
    localparam logic [7:0] SEL_DAY_LOW  = 8'h0B;
    localparam logic [7:0] SEL_DAY_HIGH = 8'h0C;

    localparam int HALT_BIT = 6;

    localparam logic [6:0] SECS_PER_MIN  = 7'd60;
    localparam logic [6:0] MINS_PER_HOUR = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY = 6'd24;

    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [7:0] day_low;
        logic [7:0] day_high;   // bit 0 day msb, bit 6 halt, bit 7 overflow
    } t_rtc;

endpackage

`default_nettype wire

// ===== rtl/cartridge_bank_mapper_with_rtc_core.sv =====
// Top level of the cartridge bank mapper with real-time clock.
// Depends on cbm_pkg and cbm_rtc_tick.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------
//   in      | in        | i_in_valid / o_in_ready   | req_type, bus_address, write_byte
//   out     | out       | o_out_valid / i_out_ready | target, mem_address, mem_write,
//           |           |                           | mem_write_byte, read_value
//   config  | in        | psel, penable, pwrite     | paddr (4*index), pwdata, prdata
//
// One transaction per cycle unless the output stalls.
// The input register feeds the decode, bank/clock update and address wrap combinationally;
// state changes land as the transaction moves into the result register.
// A stalled output holds the result; the input register still takes one more transaction.
// Synchronous active-low reset; no clearing pass, the block is ready once reset is released.
`default_nettype none

module cartridge_bank_mapper_with_rtc_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_req_type,
    input  wire  [15:0] i_bus_address,
    input  wire  [7:0]  i_write_byte,
    // output channel
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_target,
    output logic [20:0] o_mem_address,
    output logic        o_mem_write,
    output logic [7:0]  o_mem_write_byte,
    output logic [7:0]  o_read_value,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    logic [4:0] r_rom_size_log2;
    logic       r_ram_present;
    logic [3:0] r_ram_size_log2;
    logic       r_rtc_present;

    // mapper state
    logic [6:0]    r_rom_bank,        n_rom_bank;
    logic [7:0]    r_ram_bank_select, n_ram_bank_select;
    logic          r_ram_enabled,     n_ram_enabled;
    logic [7:0]    r_last_latch,      n_last_latch;
    cbm_pkg::t_rtc r_clk,             n_clk;
    cbm_pkg::t_rtc r_latched,         n_latched;
    cbm_pkg::t_rtc tick_clk;

    // input register
    logic        r_s1_valid;
    logic [1:0]  r_s1_type;
    logic [15:0] r_s1_addr;
    logic [7:0]  r_s1_data;

    // result register
    logic            r_out_valid;
    cbm_pkg::t_target r_target,     n_target;
    logic [20:0]     r_mem_address, n_mem_address;
    logic            r_mem_write,   n_mem_write;
    logic [7:0]      r_mem_wbyte,   n_mem_wbyte;
    logic [7:0]      r_read_value,  n_read_value;

    logic        in_fire;
    logic        s1_fire;
    logic        cfg_write;
    logic [2:0]  region;
    logic        in_ram;
    logic        ram_bank_ok;
    logic        rtc_reg_ok;
    logic [4:0]  rom_lg;
    logic [20:0] rom_mask;
    logic [20:0] ram_mask;
    logic [20:0] rom_phys;
    logic [20:0] ram_phys;
    logic [7:0]  rtc_read;

    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_size_log2 <= cbm_pkg::ROM_SIZE_RESET;
            r_ram_present   <= 1'b1;
            r_ram_size_log2 <= cbm_pkg::RAM_SIZE_RESET;
            r_rtc_present   <= 1'b1;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                cbm_pkg::REG_ROM_SIZE:    r_rom_size_log2 <= pwdata[4:0];
                cbm_pkg::REG_RAM_PRESENT: r_ram_present   <= pwdata[0];
                cbm_pkg::REG_RAM_SIZE:    r_ram_size_log2 <= pwdata[3:0];
                cbm_pkg::REG_RTC_PRESENT: r_rtc_present   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            cbm_pkg::REG_ROM_SIZE:    prdata = {27'd0, r_rom_size_log2};
            cbm_pkg::REG_RAM_PRESENT: prdata = {31'd0, r_ram_present};
            cbm_pkg::REG_RAM_SIZE:    prdata = {28'd0, r_ram_size_log2};
            cbm_pkg::REG_RTC_PRESENT: prdata = {31'd0, r_rtc_present};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- decode and update ----------------
    cbm_rtc_tick u_tick (
        .i_now  (r_clk),
        .o_next (tick_clk)
    );

    always_comb begin
        region      = r_s1_addr[15:13];
        in_ram      = (region == cbm_pkg::RGN_EXT_RAM) && r_ram_enabled;
        ram_bank_ok = (r_ram_bank_select <= cbm_pkg::SEL_RAM_LAST) && r_ram_present;
        rtc_reg_ok  = r_rtc_present && (r_ram_bank_select >= cbm_pkg::SEL_SECONDS)
                      && (r_ram_bank_select <= cbm_pkg::SEL_DAY_HIGH);

        // a log2 of 21 shifts the one out of the word; the subtract then gives all ones
        rom_lg   = (r_rom_size_log2 > cbm_pkg::ROM_SIZE_MAX) ? cbm_pkg::ROM_SIZE_MAX
                                                            : r_rom_size_log2;
        rom_mask = (21'd1 << rom_lg) - 21'd1;
        ram_mask = (21'd1 << r_ram_size_log2) - 21'd1;
        rom_phys = {(r_s1_addr[14] ? r_rom_bank : 7'd0), r_s1_addr[13:0]} & rom_mask;
        ram_phys = {r_ram_bank_select, r_s1_addr[12:0]} & ram_mask;

        case (r_ram_bank_select)
            cbm_pkg::SEL_SECONDS: rtc_read = {2'd0, r_latched.seconds};
            cbm_pkg::SEL_MINUTES: rtc_read = {2'd0, r_latched.minutes};
            cbm_pkg::SEL_HOURS:   rtc_read = {3'd0, r_latched.hours};
            cbm_pkg::SEL_DAY_LOW: rtc_read = r_latched.day_low;
            default:              rtc_read = r_latched.day_high;
        endcase

        n_rom_bank        = r_rom_bank;
        n_ram_bank_select = r_ram_bank_select;
        n_ram_enabled     = r_ram_enabled;
        n_last_latch      = r_last_latch;
        n_clk             = r_clk;
        n_latched         = r_latched;

        n_target      = cbm_pkg::TGT_NONE;
        n_mem_address = 21'd0;
        n_mem_write   = 1'b0;
        n_mem_wbyte   = 8'd0;
        n_read_value  = 8'd0;

        case (r_s1_type)
            cbm_pkg::REQ_READ: begin
                n_read_value = cbm_pkg::OPEN_BUS;
                if (!r_s1_addr[15]) begin
                    n_target      = cbm_pkg::TGT_ROM;
                    n_mem_address = rom_phys;
                    n_read_value  = 8'd0;
                end else if (in_ram && ram_bank_ok) begin
                    n_target      = cbm_pkg::TGT_RAM;
                    n_mem_address = ram_phys;
                    n_read_value  = 8'd0;
                end else if (in_ram && rtc_reg_ok) begin
                    n_target      = cbm_pkg::TGT_RTC;
                    n_read_value  = rtc_read;
                end
            end
            cbm_pkg::REQ_WRITE: begin
                unique case (region)
                    cbm_pkg::RGN_RAM_ENABLE: begin
                        n_ram_enabled = (r_s1_data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
                    end
                    cbm_pkg::RGN_ROM_BANK: begin
                        n_rom_bank = (r_s1_data[6:0] == 7'd0) ? 7'd1 : r_s1_data[6:0];
                    end
                    cbm_pkg::RGN_RAM_SELECT: begin
                        n_ram_bank_select = r_s1_data;
                    end
                    cbm_pkg::RGN_LATCH: begin
                        // capture the running clock on a 0 then 1 sequence
                        if (r_rtc_present && r_last_latch == cbm_pkg::LATCH_ARM
                                && r_s1_data == cbm_pkg::LATCH_FIRE) begin
                            n_latched = r_clk;
                        end
                        n_last_latch = r_s1_data;
                    end
                    cbm_pkg::RGN_EXT_RAM: begin
                        if (in_ram && ram_bank_ok) begin
                            n_target      = cbm_pkg::TGT_RAM;
                            n_mem_address = ram_phys;
                            n_mem_write   = 1'b1;
                            n_mem_wbyte   = r_s1_data;
                        end else if (in_ram && rtc_reg_ok) begin
                            n_target = cbm_pkg::TGT_RTC;
                            case (r_ram_bank_select)
                                cbm_pkg::SEL_SECONDS: n_clk.seconds = r_s1_data[5:0];
                                cbm_pkg::SEL_MINUTES: n_clk.minutes = r_s1_data[5:0];
                                cbm_pkg::SEL_HOURS:   n_clk.hours   = r_s1_data[4:0];
                                cbm_pkg::SEL_DAY_LOW: n_clk.day_low = r_s1_data;
                                default:              n_clk.day_high = r_s1_data;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            cbm_pkg::REQ_TICK: begin
                if (r_rtc_present && !r_clk.day_high[cbm_pkg::HALT_BIT]) begin
                    n_clk = tick_clk;
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_rom_bank        <= 7'd1;
            r_ram_bank_select <= 8'd0;
            r_ram_enabled     <= 1'b0;
            r_last_latch      <= 8'd0;
            r_clk             <= '0;
            r_latched         <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // state advances only as a transaction leaves the input register
            if (s1_fire) begin
                r_rom_bank        <= n_rom_bank;
                r_ram_bank_select <= n_ram_bank_select;
                r_ram_enabled     <= n_ram_enabled;
                r_last_latch      <= n_last_latch;
                r_clk             <= n_clk;
                r_latched         <= n_latched;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_type <= i_req_type;
            r_s1_addr <= i_bus_address;
            r_s1_data <= i_write_byte;
        end
        if (s1_fire) begin
            r_target      <= n_target;
            r_mem_address <= n_mem_address;
            r_mem_write   <= n_mem_write;
            r_mem_wbyte   <= n_mem_wbyte;
            r_read_value  <= n_read_value;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_target         = r_target;
    assign o_mem_address    = r_mem_address;
    assign o_mem_write      = r_mem_write;
    assign o_mem_write_byte = r_mem_wbyte;
    assign o_read_value     = r_read_value;

    // ---------------- assertions ----------------
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input register taken while its transaction is blocked");

    a_rom_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_type == cbm_pkg::REQ_WRITE && r_s1_addr[15:13] == cbm_pkg::RGN_ROM_BANK
        |=> r_rom_bank == (($past(r_s1_data[6:0]) == 7'd0) ? 7'd1 : $past(r_s1_data[6:0])))
        else $error("rom bank write not applied with zero mapped to one");

    a_halt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_type == cbm_pkg::REQ_TICK && r_clk.day_high[cbm_pkg::HALT_BIT]
        |=> r_clk == $past(r_clk))
        else $error("halted clock advanced on a tick");

    a_rtc_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_target == cbm_pkg::TGT_RTC |-> o_mem_address == 21'd0 && !o_mem_write)
        else $error("clock register transaction carries a memory address or write");

endmodule

`default_nettype wire

// ===== rtl/cbm_rtc_tick.sv =====
// One-second advance of the clock registers: seconds, minutes, hours, 9-bit day.
// Depends on cbm_pkg for t_rtc and the unit limits.
`default_nettype none

module cbm_rtc_tick (
    input  wire cbm_pkg::t_rtc i_now,
    output cbm_pkg::t_rtc      o_next
);

    logic [6:0] sec_sum;
    logic [6:0] min_sum;
    logic [5:0] hour_sum;
    logic [9:0] day_sum;
    logic       sec_carry;
    logic       min_carry;
    logic       hour_carry;

    always_comb begin
        // each sum stays below twice its unit, so one subtract reduces it
        sec_sum   = {1'b0, i_now.seconds} + 7'd1;
        sec_carry = (sec_sum >= cbm_pkg::SECS_PER_MIN);
        min_sum   = {1'b0, i_now.minutes} + {6'd0, sec_carry};
        min_carry = (min_sum >= cbm_pkg::MINS_PER_HOUR);
        hour_sum  = {1'b0, i_now.hours} + {5'd0, min_carry};
        hour_carry = (hour_sum >= cbm_pkg::HOURS_PER_DAY);
        day_sum   = {1'b0, i_now.day_high[0], i_now.day_low} + {9'd0, hour_carry};

        o_next.seconds  = sec_carry ? 6'(sec_sum - cbm_pkg::SECS_PER_MIN) : sec_sum[5:0];
        o_next.minutes  = min_carry ? 6'(min_sum - cbm_pkg::MINS_PER_HOUR) : min_sum[5:0];
        o_next.hours    = hour_carry ? 5'(hour_sum - cbm_pkg::HOURS_PER_DAY)
                                     : hour_sum[4:0];
        o_next.day_low  = day_sum[7:0];
        // overflow bit is sticky
        o_next.day_high = {i_now.day_high[7] | day_sum[9], i_now.day_high[6:1], day_sum[8]};
    end

endmodule

`default_nettype wire
